// ===== hw/rtl/sadp_pkg.sv =====
// Shared types and constants for the shifter ALU data-processing block.
// Holds the packed request and response layouts, opcode and shift codes.
// No dependencies; every other file imports this package.
package sadp_pkg;

   localparam int REQ_WIDTH = 96;
   localparam int RSP_WIDTH = 48;
   localparam int DATA_WIDTH = 32;

   typedef enum logic [3:0] {
      OP_AND = 4'h0,
      OP_EOR = 4'h1,
      OP_SUB = 4'h2,
      OP_RSB = 4'h3,
      OP_ADD = 4'h4,
      OP_ADC = 4'h5,
      OP_SBC = 4'h6,
      OP_RSC = 4'h7,
      OP_TST = 4'h8,
      OP_TEQ = 4'h9,
      OP_CMP = 4'hA,
      OP_CMN = 4'hB,
      OP_ORR = 4'hC,
      OP_MOV = 4'hD,
      OP_BIC = 4'hE,
      OP_MVN = 4'hF
   } alu_op_type;

   typedef enum logic [1:0] {
      SHIFT_LSL = 2'd0,
      SHIFT_LSR = 2'd1,
      SHIFT_ASR = 2'd2,
      SHIFT_ROR = 2'd3
   } shift_kind_type;

   // Request layout, last member in the lowest bits.
   typedef struct packed {
      logic                    pad;
      logic                    spsr_thumb;
      logic                    rm_is_pc;
      logic                    rn_is_pc;
      logic                    rd_is_pc;
      logic                    carry_in;
      logic [7:0]              rs_low;
      logic [DATA_WIDTH-1:0]   rm_value;
      logic [DATA_WIDTH-1:0]   rn_value;
      logic [11:0]             operand_field;
      logic                    imm_form;
      logic                    set_flags;
      alu_op_type              opcode;
   } req_type;

   // Response layout, last member in the lowest bits.
   typedef struct packed {
      logic [6:0]              pad;
      logic                    restore_psr;
      logic                    new_v;
      logic                    write_v;
      logic                    new_c;
      logic                    write_c;
      logic                    new_z;
      logic                    new_n;
      logic                    write_nz;
      logic                    write_reg;
      logic [DATA_WIDTH-1:0]   result;
   } rsp_type;

   // Operand stage results handed to the ALU.
   typedef struct packed {
      logic [DATA_WIDTH-1:0]   op2;
      logic                    shift_carry;
      logic [DATA_WIDTH-1:0]   rn_eff;
   } operand_type;

endpackage

// ===== hw/rtl/sadp_operand.sv =====
// Operand 2 builder: rotated immediate or barrel-shifted register.
// Also applies the program-counter read offset for register shifts.
// Depends on sadp_pkg.
module sadp_operand (
   input  sadp_pkg::req_type     req,
   output sadp_pkg::operand_type opnd
);
   import sadp_pkg::*;

   logic                  by_reg;
   shift_kind_type        kind;
   logic [7:0]            amt;
   logic [4:0]            amt_lo;
   logic [4:0]            rot;
   logic [DATA_WIDTH-1:0] imm_val;
   logic [DATA_WIDTH-1:0] v;
   logic [DATA_WIDTH-1:0] fill;
   logic [DATA_WIDTH-1:0] sh_val;
   logic                  sh_c;
   logic                  cin;

   assign cin    = req.carry_in;
   assign by_reg = req.operand_field[4];
   assign kind   = shift_kind_type'(req.operand_field[6:5]);
   assign amt    = by_reg ? req.rs_low : {3'b000, req.operand_field[11:7]};
   assign amt_lo = amt[4:0];
   assign rot    = {req.operand_field[11:8], 1'b0};
   assign imm_val = {24'd0, req.operand_field[7:0]};
   assign v      = (by_reg && req.rm_is_pc) ? req.rm_value + 32'd4 : req.rm_value;
   assign fill   = {DATA_WIDTH{v[DATA_WIDTH-1]}};

   always_comb begin
      sh_val = v;
      sh_c   = cin;
      if (!by_reg && amt == 8'd0) begin
         unique case (kind)
            SHIFT_LSL: begin
               sh_val = v;
               sh_c   = cin;
            end
            SHIFT_LSR: begin
               sh_val = '0;
               sh_c   = v[31];
            end
            SHIFT_ASR: begin
               sh_val = fill;
               sh_c   = v[31];
            end
            SHIFT_ROR: begin
               sh_val = {cin, v[31:1]};
               sh_c   = v[0];
            end
         endcase
      end else if (amt != 8'd0) begin
         unique case (kind)
            SHIFT_LSL: begin
               if (amt < 8'd32) begin
                  sh_val = v << amt_lo;
                  sh_c   = v[5'(6'd32 - {1'b0, amt_lo})];
               end else begin
                  sh_val = '0;
                  sh_c   = (amt == 8'd32) ? v[0] : 1'b0;
               end
            end
            SHIFT_LSR: begin
               if (amt < 8'd32) begin
                  sh_val = v >> amt_lo;
                  sh_c   = v[amt_lo - 5'd1];
               end else begin
                  sh_val = '0;
                  sh_c   = (amt == 8'd32) ? v[31] : 1'b0;
               end
            end
            SHIFT_ASR: begin
               if (amt < 8'd32) begin
                  sh_val = DATA_WIDTH'($signed(v) >>> amt_lo);
                  sh_c   = v[amt_lo - 5'd1];
               end else begin
                  sh_val = fill;
                  sh_c   = v[31];
               end
            end
            SHIFT_ROR: begin
               if (amt_lo == 5'd0) begin
                  sh_val = v;
                  sh_c   = v[31];
               end else begin
                  sh_val = (v >> amt_lo) | (v << (5'(6'd32 - {1'b0, amt_lo})));
                  sh_c   = sh_val[31];
               end
            end
         endcase
      end
   end

   always_comb begin
      opnd.rn_eff = (!req.imm_form && by_reg && req.rn_is_pc) ?
                    req.rn_value + 32'd4 : req.rn_value;
      if (req.imm_form) begin
         if (rot == 5'd0) begin
            opnd.op2         = imm_val;
            opnd.shift_carry = cin;
         end else begin
            opnd.op2         = (imm_val >> rot) | (imm_val << (5'(6'd32 - {1'b0, rot})));
            opnd.shift_carry = opnd.op2[31];
         end
      end else begin
         opnd.op2         = sh_val;
         opnd.shift_carry = sh_c;
      end
   end

endmodule

// ===== hw/rtl/sadp_alu.sv =====
// Sixteen-opcode ALU with adder, logic unit and flag update decode.
// Takes the request and the operand stage output, gives one response.
// Depends on sadp_pkg.
module sadp_alu (
   input  sadp_pkg::req_type     req,
   input  sadp_pkg::operand_type opnd,
   output sadp_pkg::rsp_type     rsp
);
   import sadp_pkg::*;

   logic [DATA_WIDTH-1:0] rn;
   logic [DATA_WIDTH-1:0] op2;
   logic [DATA_WIDTH-1:0] add_a;
   logic [DATA_WIDTH-1:0] add_b;
   logic                  add_ci;
   logic [DATA_WIDTH:0]   sum;
   logic                  add_v;
   logic                  arith;
   logic                  is_test;
   logic                  s_eff;
   logic [DATA_WIDTH-1:0] val;
   logic [DATA_WIDTH-1:0] final_val;

   assign rn  = opnd.rn_eff;
   assign op2 = opnd.op2;

   always_comb begin
      add_a  = rn;
      add_b  = op2;
      add_ci = 1'b0;
      arith  = 1'b1;
      val    = '0;
      unique case (req.opcode)
         OP_AND, OP_TST: begin
            arith = 1'b0;
            val   = rn & op2;
         end
         OP_EOR, OP_TEQ: begin
            arith = 1'b0;
            val   = rn ^ op2;
         end
         OP_SUB, OP_CMP: begin
            add_b  = ~op2;
            add_ci = 1'b1;
         end
         OP_RSB: begin
            add_a  = op2;
            add_b  = ~rn;
            add_ci = 1'b1;
         end
         OP_ADD, OP_CMN: begin
            add_ci = 1'b0;
         end
         OP_ADC: begin
            add_ci = req.carry_in;
         end
         OP_SBC: begin
            add_b  = ~op2;
            add_ci = req.carry_in;
         end
         OP_RSC: begin
            add_a  = op2;
            add_b  = ~rn;
            add_ci = req.carry_in;
         end
         OP_ORR: begin
            arith = 1'b0;
            val   = rn | op2;
         end
         OP_MOV: begin
            arith = 1'b0;
            val   = op2;
         end
         OP_BIC: begin
            arith = 1'b0;
            val   = rn & ~op2;
         end
         OP_MVN: begin
            arith = 1'b0;
            val   = ~op2;
         end
      endcase
   end

   assign sum     = {1'b0, add_a} + {1'b0, add_b} + {{DATA_WIDTH{1'b0}}, add_ci};
   assign add_v   = (~(add_a[31] ^ add_b[31])) & (add_a[31] ^ sum[31]);
   assign is_test = (req.opcode == OP_TST) || (req.opcode == OP_TEQ) ||
                    (req.opcode == OP_CMP) || (req.opcode == OP_CMN);
   assign s_eff   = req.set_flags && !req.rd_is_pc;

   always_comb begin
      final_val = arith ? sum[DATA_WIDTH-1:0] : val;
      if (req.rd_is_pc && req.set_flags && req.spsr_thumb && !is_test) begin
         final_val[0] = 1'b1;
      end
      rsp             = '0;
      rsp.result      = final_val;
      rsp.write_reg   = !is_test;
      rsp.new_n       = final_val[31];
      rsp.new_z       = (final_val == '0);
      rsp.new_c       = arith ? sum[DATA_WIDTH] : opnd.shift_carry;
      rsp.new_v       = arith ? add_v : 1'b0;
      rsp.restore_psr = req.rd_is_pc && req.set_flags;
      if (is_test) begin
         rsp.write_nz = 1'b1;
         rsp.write_c  = arith ? 1'b1 : s_eff;
         rsp.write_v  = arith;
      end else begin
         rsp.write_nz = s_eff;
         rsp.write_c  = s_eff;
         rsp.write_v  = s_eff && arith;
      end
   end

endmodule

// ===== hw/rtl/shifter_alu_data_processing.sv =====
// Top level of the shifter ALU: input register, operand and ALU logic, result register.
// Instantiates sadp_operand and sadp_alu; depends on sadp_pkg.
//
//   Channel | Direction | Handshake             | Payload
//   req     | in        | req_tvalid/req_tready | req_tdata, 96 bits
//   rsp     | out       | rsp_tvalid/rsp_tready | rsp_tdata, 48 bits
//
// A request is captured in the input register when accepted; while it sits there the shifter
// and adder work on it, and the result register loads their output once it is free, so the
// response is offered from the result register.
// One request is accepted every cycle while the response side keeps up.
// When the response is stalled, the result register holds and req_tready drops once the
// input register is also full.
// Reset is synchronous, active high, and clears both valid bits.
module shifter_alu_data_processing (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [3:0] opcode, [4] set_flags, [5] imm_form, [17:6] operand_field,
   // [49:18] rn_value, [81:50] rm_value, [89:82] rs_low, [90] carry_in,
   // [91] rd_is_pc, [92] rn_is_pc, [93] rm_is_pc, [94] spsr_thumb, [95] zero
   input  logic [sadp_pkg::REQ_WIDTH-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [31:0] result, [32] write_reg, [33] write_nz, [34] new_n, [35] new_z,
   // [36] write_c, [37] new_c, [38] write_v, [39] new_v, [40] restore_psr,
   // [47:41] zero
   output logic [sadp_pkg::RSP_WIDTH-1:0]  rsp_tdata
);
   import sadp_pkg::*;

   logic        stage_valid_ff;
   logic        stage_valid_in;
   req_type     stage_ff;
   req_type     stage_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;
   rsp_type     alu_rsp;
   operand_type opnd;
   logic        out_open;
   logic        req_fire;

   assign out_open   = rsp_tready || !rsp_valid_ff;
   assign req_tready = !stage_valid_ff || out_open;
   assign req_fire   = req_tvalid && req_tready;

   sadp_operand u_operand (
      .req  (stage_ff),
      .opnd (opnd)
   );

   sadp_alu u_alu (
      .req  (stage_ff),
      .opnd (opnd),
      .rsp  (alu_rsp)
   );

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_in       = stage_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;
      if (out_open) begin
         rsp_valid_in = stage_valid_ff;
         rsp_in       = alu_rsp;
      end
      if (req_tready) begin
         stage_valid_in = req_tvalid;
      end
      if (req_fire) begin
         stage_in = req_type'(req_tdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      stage_ff <= stage_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_WIDTH'(rsp_ff);

`ifndef SYNTHESIS
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !out_open |=> stage_valid_ff && $stable(stage_ff))
      else $error("Input register changed while the result register was stalled.");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && out_open |=> rsp_valid_ff)
      else $error("A request left the input register without reaching the output.");

   a_pc_write_no_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.restore_psr && rsp_ff.write_reg |->
      !rsp_ff.write_nz && !rsp_ff.write_c && !rsp_ff.write_v)
      else $error("Flags updated on a status restoring PC write.");

   a_v_needs_c: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.write_v |-> rsp_ff.write_c && rsp_ff.write_nz)
      else $error("Overflow update without carry and NZ update.");

   a_test_sets_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.write_reg |-> rsp_ff.write_nz)
      else $error("Compare or test request without NZ update.");
`endif

endmodule

// ===== tb/sv/shifter_alu_data_processing_tb.sv =====
// Self-checking testbench for the shifter ALU data-processing block.
// Drives requests with random gaps and backpressure, and predicts each response.
// Depends on sadp_pkg and shifter_alu_data_processing.
module shifter_alu_data_processing_tb;
   import sadp_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int LONG_HOLD = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_WIDTH-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_WIDTH-1:0] rsp_tdata;

   rsp_type expected_rsp_q[$];
   int error_count = 0;
   int quiet_cycles = 0;
   bit no_idle = 1'b0;
   bit hold_rsp_request = 1'b0;

   shifter_alu_data_processing dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 50) begin
         return 0;
      end
      if (roll < 85) begin
         return $urandom_range(1, 3);
      end
      if (roll < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [11:0] shift_field(input logic [4:0] amount,
                                               input shift_kind_type kind,
                                               input logic by_reg);
      return {amount, kind, by_reg, 4'h0};
   endfunction

   function automatic rsp_type alu_predict(input req_type q);
      rsp_type o;
      logic [31:0] rn, rm, op2, val, a, b;
      logic [32:0] sum;
      logic [7:0] amount;
      logic [4:0] rot_amt;
      logic sc, c, v, add_cin, arith, compare, s_eff, by_reg;
      shift_kind_type kind;
      int n;
      rn = q.rn_value;
      rm = q.rm_value;
      sc = q.carry_in;
      s_eff = q.set_flags && !q.rd_is_pc;
      if (q.imm_form) begin
         n = int'({q.operand_field[11:8], 1'b0});
         op2 = {24'h0, q.operand_field[7:0]};
         if (n != 0) begin
            op2 = (op2 >> n) | (op2 << (32 - n));
            sc = op2[31];
         end
      end else begin
         by_reg = q.operand_field[4];
         kind = shift_kind_type'(q.operand_field[6:5]);
         amount = by_reg ? q.rs_low : {3'b000, q.operand_field[11:7]};
         n = int'(amount);
         if (by_reg) begin
            if (q.rm_is_pc) rm = rm + 32'd4;
            if (q.rn_is_pc) rn = rn + 32'd4;
         end
         op2 = rm;
         if (!by_reg && n == 0) begin
            case (kind)
               SHIFT_LSL: op2 = rm;
               SHIFT_LSR: begin
                  sc = rm[31];
                  op2 = '0;
               end
               SHIFT_ASR: begin
                  sc = rm[31];
                  op2 = {32{rm[31]}};
               end
               default: begin
                  sc = rm[0];
                  op2 = {q.carry_in, rm[31:1]};
               end
            endcase
         end else if (n != 0) begin
            case (kind)
               SHIFT_LSL: begin
                  if (n < 32) begin
                     sc = rm[32 - n];
                     op2 = rm << n;
                  end else begin
                     sc = (n == 32) ? rm[0] : 1'b0;
                     op2 = '0;
                  end
               end
               SHIFT_LSR: begin
                  if (n < 32) begin
                     sc = rm[n - 1];
                     op2 = rm >> n;
                  end else begin
                     sc = (n == 32) ? rm[31] : 1'b0;
                     op2 = '0;
                  end
               end
               SHIFT_ASR: begin
                  if (n < 32) begin
                     sc = rm[n - 1];
                     op2 = $signed(rm) >>> n;
                  end else begin
                     sc = rm[31];
                     op2 = {32{rm[31]}};
                  end
               end
               default: begin
                  rot_amt = amount[4:0];
                  if (rot_amt == 0) begin
                     sc = rm[31];
                  end else begin
                     op2 = (rm >> rot_amt) | (rm << (32 - rot_amt));
                     sc = op2[31];
                  end
               end
            endcase
         end
      end

      arith = 1'b1;
      a = rn;
      b = op2;
      add_cin = 1'b0;
      val = '0;
      case (q.opcode)
         OP_AND, OP_TST: begin
            arith = 1'b0;
            val = rn & op2;
         end
         OP_EOR, OP_TEQ: begin
            arith = 1'b0;
            val = rn ^ op2;
         end
         OP_ORR: begin
            arith = 1'b0;
            val = rn | op2;
         end
         OP_MOV: begin
            arith = 1'b0;
            val = op2;
         end
         OP_BIC: begin
            arith = 1'b0;
            val = rn & ~op2;
         end
         OP_MVN: begin
            arith = 1'b0;
            val = ~op2;
         end
         OP_SUB, OP_CMP: begin
            b = ~op2;
            add_cin = 1'b1;
         end
         OP_RSB: begin
            a = op2;
            b = ~rn;
            add_cin = 1'b1;
         end
         OP_ADC: add_cin = q.carry_in;
         OP_SBC: begin
            b = ~op2;
            add_cin = q.carry_in;
         end
         OP_RSC: begin
            a = op2;
            b = ~rn;
            add_cin = q.carry_in;
         end
         default: add_cin = 1'b0;
      endcase
      if (arith) begin
         sum = {1'b0, a} + {1'b0, b} + {32'h0, add_cin};
         val = sum[31:0];
         c = sum[32];
         v = ~(a[31] ^ b[31]) & (a[31] ^ val[31]);
      end else begin
         c = sc;
         v = 1'b0;
      end

      o = '0;
      compare = (q.opcode >= OP_TST) && (q.opcode <= OP_CMN);
      o.write_reg = !compare;
      if (compare) begin
         o.write_nz = 1'b1;
         o.write_c = arith || s_eff;
         o.write_v = arith;
      end else begin
         o.write_nz = s_eff;
         o.write_c = s_eff;
         o.write_v = s_eff && arith;
      end
      if (q.rd_is_pc && q.set_flags && q.spsr_thumb && !compare) val[0] = 1'b1;
      o.result = val;
      o.new_n = val[31];
      o.new_z = (val == 32'h0);
      o.new_c = c;
      o.new_v = v;
      o.restore_psr = q.rd_is_pc && q.set_flags;
      return o;
   endfunction

   function automatic req_type random_request(input bit pc_heavy);
      req_type q;
      q = '0;
      q.opcode = alu_op_type'($urandom_range(0, 15));
      q.set_flags = 1'($urandom_range(0, 1));
      q.imm_form = ($urandom_range(0, 2) == 0);
      q.operand_field = 12'($urandom_range(0, 4095));
      if (!q.imm_form && $urandom_range(0, 4) == 0) q.operand_field[11:7] = 5'd0;
      if (pc_heavy) q.operand_field[4] = 1'b1;
      q.rn_value = pick_word();
      q.rm_value = pick_word();
      case ($urandom_range(0, 6))
         0: q.rs_low = 8'd0;
         1: q.rs_low = 8'd32;
         2: q.rs_low = 8'd64;
         3: q.rs_low = 8'($urandom_range(33, 255));
         default: q.rs_low = 8'($urandom_range(1, 31));
      endcase
      q.carry_in = 1'($urandom_range(0, 1));
      q.rd_is_pc = ($urandom_range(0, pc_heavy ? 1 : 7) == 0);
      q.rn_is_pc = ($urandom_range(0, pc_heavy ? 1 : 7) == 0);
      q.rm_is_pc = ($urandom_range(0, pc_heavy ? 1 : 7) == 0);
      q.spsr_thumb = 1'($urandom_range(0, 1));
      return q;
   endfunction

   // Called at a rising edge; returns at the edge where the request is taken.
   task automatic send_request(input req_type q);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= q;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_rsp_q.size() != 0);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < 40) begin
         $display("%0t: response mismatch in %s: got %h, expected %h", $time, what, got, want);
      end
      error_count++;
   endtask

   task automatic test_directed_cases();
      req_type r;
      for (int i = 0; i < 16; i++) begin
         r = '0;
         r.opcode = alu_op_type'(i);
         r.set_flags = (i < 8) ? 1'b1 : i[0];
         r.imm_form = (i >= 8);
         r.operand_field = i[0] ? 12'hFFF : 12'h000;
         r.rn_value = i[1] ? 32'hFFFF_FFFF : 32'h8000_0000;
         r.rm_value = i[2] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         r.rs_low = 8'hFF;
         r.carry_in = i[0] ^ i[1];
         r.rd_is_pc = (i >= 8);
         r.spsr_thumb = (i >= 12);
         send_request(r);
      end
      for (int k = 0; k < 11; k++) begin
         r = '0;
         r.opcode = OP_MOV;
         r.set_flags = 1'b1;
         r.rm_value = 32'h8000_0001;
         r.carry_in = 1'b1;
         case (k)
            0: r.operand_field = shift_field(5'd0, SHIFT_LSR, 1'b0);
            1: r.operand_field = shift_field(5'd0, SHIFT_ASR, 1'b0);
            2: r.operand_field = shift_field(5'd0, SHIFT_ROR, 1'b0);
            3: begin
               r.operand_field = shift_field(5'd0, SHIFT_LSL, 1'b1);
               r.rs_low = 8'd32;
            end
            4: begin
               r.operand_field = shift_field(5'd0, SHIFT_LSR, 1'b1);
               r.rs_low = 8'd32;
            end
            5: begin
               r.operand_field = shift_field(5'd0, SHIFT_LSR, 1'b1);
               r.rs_low = 8'd33;
            end
            6: begin
               r.operand_field = shift_field(5'd0, SHIFT_ASR, 1'b1);
               r.rs_low = 8'd200;
            end
            7: begin
               r.operand_field = shift_field(5'd0, SHIFT_ROR, 1'b1);
               r.rs_low = 8'd64;
            end
            8: begin
               r.operand_field = shift_field(5'd31, SHIFT_LSL, 1'b1);
               r.rs_low = 8'd0;
               r.carry_in = 1'b0;
            end
            9: begin
               r.imm_form = 1'b1;
               r.operand_field = 12'h0FF;
            end
            default: begin
               r.opcode = OP_ADD;
               r.operand_field = shift_field(5'd0, SHIFT_LSL, 1'b1);
               r.rs_low = 8'd1;
               r.rn_value = 32'hFFFF_FFFC;
               r.rn_is_pc = 1'b1;
               r.rm_is_pc = 1'b1;
            end
         endcase
         send_request(r);
      end
   endtask

   task automatic test_random_mix(input int count);
      for (int i = 0; i < count; i++) send_request(random_request(1'b0));
   endtask

   task automatic test_pc_operands(input int count);
      for (int i = 0; i < count; i++) send_request(random_request(1'b1));
   endtask

   task automatic test_back_to_back(input int count);
      no_idle = 1'b1;
      for (int i = 0; i < count; i++) send_request(random_request(1'b0));
      no_idle = 1'b0;
   endtask

   task automatic test_backpressure(input int count);
      hold_rsp_request = 1'b1;
      no_idle = 1'b1;
      for (int i = 0; i < count; i++) send_request(random_request(1'b0));
      no_idle = 1'b0;
      wait_for_drain();
   endtask

   initial begin : rsp_ready_driver
      int stall_left;
      int run_left;
      stall_left = 0;
      run_left = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            stall_left = LONG_HOLD;
            run_left = 0;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (no_idle || run_left > 0) begin
            rsp_tready <= 1'b1;
            if (run_left > 0) run_left--;
         end else begin
            rsp_tready <= 1'b1;
            run_left = $urandom_range(0, 30);
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata);
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("unexpected response", got.result, 32'h0);
            end else begin
               want = expected_rsp_q.pop_front();
               if (got.result !== want.result)
                  report_mismatch("result", got.result, want.result);
               if (got.write_reg !== want.write_reg)
                  report_mismatch("write_reg", 32'(got.write_reg), 32'(want.write_reg));
               if (got.write_nz !== want.write_nz)
                  report_mismatch("write_nz", 32'(got.write_nz), 32'(want.write_nz));
               if (got.new_n !== want.new_n)
                  report_mismatch("new_n", 32'(got.new_n), 32'(want.new_n));
               if (got.new_z !== want.new_z)
                  report_mismatch("new_z", 32'(got.new_z), 32'(want.new_z));
               if (got.write_c !== want.write_c)
                  report_mismatch("write_c", 32'(got.write_c), 32'(want.write_c));
               if (got.new_c !== want.new_c)
                  report_mismatch("new_c", 32'(got.new_c), 32'(want.new_c));
               if (got.write_v !== want.write_v)
                  report_mismatch("write_v", 32'(got.write_v), 32'(want.write_v));
               if (got.new_v !== want.new_v)
                  report_mismatch("new_v", 32'(got.new_v), 32'(want.new_v));
               if (got.restore_psr !== want.restore_psr)
                  report_mismatch("restore_psr", 32'(got.restore_psr),
                                  32'(want.restore_psr));
            end
         end
         if (req_tvalid && req_tready) begin
            expected_rsp_q.push_back(alu_predict(req_type'(req_tdata)));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_mix(1200);
      test_backpressure(40);
      test_pc_operands(150);
      test_back_to_back(180);
      wait_for_drain();
      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_rsp_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
